[sv/signed_radix_digit_sequencer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the signed radix digit sequencer
// Concurrent property wrappers clocked on clk_i, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_RADIX_DIGIT_SEQUENCER_MACROS_SVH
`define SIGNED_RADIX_DIGIT_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define SRDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/srds_pkg.sv]
// ----------------------------------------------------------------------------
// srds_pkg
// Shared types and codes of the signed radix digit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package srds_pkg;

  // Configuration register indexes
  localparam logic CFG_NUMBER_BASE = 1'b0;
  localparam logic CFG_PAD_DIGITS  = 1'b1;

  localparam int unsigned BASE_W  = 5;
  localparam int unsigned MIND_W  = 7;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
  localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;

  // Stored element encoding: gap, digit 1..15, negative marker
  localparam logic [4:0] EL_GAP = 5'd0;
  localparam logic [4:0] EL_NEG = 5'd16;

  // Result element kinds
  localparam logic [1:0] KIND_DIGIT = 2'd0;
  localparam logic [1:0] KIND_GAP   = 2'd1;
  localparam logic [1:0] KIND_NEG   = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_BIT,
    OP_PUT_DIGIT,
    OP_PUT_GAP,
    OP_PUT_NEG,
    OP_READ,
    OP_EMIT
  } srds_op_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NEVER,
    COND_NO_INPUT,
    COND_MORE_BITS,
    COND_MAG_NZ,
    COND_PAD_DONE,
    COND_NOT_NEG,
    COND_NOT_LAST
  } srds_cond_e;

  localparam int unsigned UPC_W = 4;

  typedef struct packed {
    srds_op_e         op;
    srds_cond_e       cond;
    logic [UPC_W-1:0] target;
  } srds_uword_t;

  typedef struct packed {
    logic in_valid;
    logic more_bits;
    logic mag_nz;
    logic pad_done;
    logic neg;
    logic last;
    logic out_free;
  } srds_status_t;

endpackage

`default_nettype wire

[sv/srds_ucode_rom.sv]
// ----------------------------------------------------------------------------
// srds_ucode_rom
// Control store: one control word per program step.
// ----------------------------------------------------------------------------
`default_nettype none

module srds_ucode_rom (
  input  logic [srds_pkg::UPC_W-1:0] upc_i,
  output srds_pkg::srds_uword_t      uword_o
);
  import srds_pkg::*;

  always_comb begin
    unique case (upc_i)
      // wait for a code, load magnitude and sign
      4'd0:    uword_o = '{op: OP_LOAD,      cond: COND_NO_INPUT,  target: 4'd0};
      // one quotient bit per cycle
      4'd1:    uword_o = '{op: OP_DIV_BIT,   cond: COND_MORE_BITS, target: 4'd1};
      // store remainder as digit, divide again while magnitude is left
      4'd2:    uword_o = '{op: OP_PUT_DIGIT, cond: COND_MAG_NZ,    target: 4'd1};
      4'd3:    uword_o = '{op: OP_NOP,       cond: COND_PAD_DONE,  target: 4'd5};
      4'd4:    uword_o = '{op: OP_PUT_GAP,   cond: COND_ALWAYS,    target: 4'd3};
      4'd5:    uword_o = '{op: OP_NOP,       cond: COND_NOT_NEG,   target: 4'd7};
      4'd6:    uword_o = '{op: OP_PUT_NEG,   cond: COND_NEVER,     target: 4'd7};
      // read element, then emit it once the output slot is free
      4'd7:    uword_o = '{op: OP_READ,      cond: COND_NEVER,     target: 4'd8};
      4'd8:    uword_o = '{op: OP_EMIT,      cond: COND_NOT_LAST,  target: 4'd7};
      4'd9:    uword_o = '{op: OP_NOP,       cond: COND_ALWAYS,    target: 4'd0};
      default: uword_o = '{op: OP_NOP,       cond: COND_ALWAYS,    target: 4'd0};
    endcase
  end

endmodule

`default_nettype wire

[sv/srds_sequencer.sv]
// ----------------------------------------------------------------------------
// srds_sequencer
// Step counter with conditional jumps; holds on a busy output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module srds_sequencer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  srds_pkg::srds_uword_t      uword_i,
  input  srds_pkg::srds_status_t     status_i,
  output logic [srds_pkg::UPC_W-1:0] upc_o
);
  import srds_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d;
  logic             jump;
  logic             hold;

  always_comb begin
    unique case (uword_i.cond)
      COND_ALWAYS:    jump = 1'b1;
      COND_NEVER:     jump = 1'b0;
      COND_NO_INPUT:  jump = !status_i.in_valid;
      COND_MORE_BITS: jump = status_i.more_bits;
      COND_MAG_NZ:    jump = status_i.mag_nz;
      COND_PAD_DONE:  jump = status_i.pad_done;
      COND_NOT_NEG:   jump = !status_i.neg;
      COND_NOT_LAST:  jump = !status_i.last;
      default:        jump = 1'b0;
    endcase
  end

  assign hold = (uword_i.op == OP_EMIT) && !status_i.out_free;

  always_comb begin
    priority if (hold) begin
      upc_d = upc_q;
    end else if (jump) begin
      upc_d = uword_i.target;
    end else begin
      upc_d = upc_q + UPC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= '0;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign upc_o = upc_q;

endmodule

`default_nettype wire

[sv/srds_datapath.sv]
// ----------------------------------------------------------------------------
// srds_datapath
// Config registers, bit-serial divider, element store and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srds_datapath #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned CODE_WIDTH = 32,
  localparam int unsigned IN_W      = ((CODE_WIDTH + 7) / 8) * 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  srds_pkg::srds_uword_t                uword_i,
  output srds_pkg::srds_status_t               status_o,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [srds_pkg::MIND_W-1:0]          cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [IN_W-1:0]                      in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [srds_pkg::OUT_TDATA_W-1:0]     out_data_o,
  output logic                                 out_last_o
);
  import srds_pkg::*;

  localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned BCW = $clog2(CODE_WIDTH);

  logic [BASE_W-1:0] base_q;
  logic [MIND_W-1:0] pad_digits_q;
  logic [BASE_W-1:0] base_sat;

  logic [CODE_WIDTH-1:0] mag_q;
  logic [3:0]            rem_q;
  logic [BCW-1:0]        bitcnt_q;
  logic                  neg_q;
  logic [MIND_W-1:0]     digits_q;
  logic [CW-1:0]         count_q;
  logic [CW-1:0]         rp_q;

  logic [4:0] mem [CAPACITY];
  logic [4:0] rd_q;

  logic                  out_valid_q;
  logic [1:0]            kind_q;
  logic [3:0]            digit_q;
  logic                  last_q;

  logic [CODE_WIDTH-1:0] code;
  logic [CODE_WIDTH-1:0] code_abs;
  logic [4:0]            rem_sh;
  logic                  q_bit;
  logic [4:0]            rem_sub;
  logic                  in_fire;
  logic                  put;
  logic [4:0]            put_el;
  logic                  room;
  logic                  emit_fire;
  logic [CW-1:0]         rd_addr;
  logic                  last;

  // Saturate the radix into 2..16
  always_comb begin
    priority if (base_q < BASE_MIN) begin
      base_sat = BASE_MIN;
    end else if (base_q > BASE_MAX) begin
      base_sat = BASE_MAX;
    end else begin
      base_sat = base_q;
    end
  end

  assign code     = in_data_i[CODE_WIDTH-1:0];
  assign code_abs = code[CODE_WIDTH-1] ? (~code + CODE_WIDTH'(1)) : code;

  // Restoring division step: bring in the next magnitude bit
  assign rem_sh  = {rem_q, mag_q[CODE_WIDTH-1]};
  assign q_bit   = (rem_sh >= base_sat);
  assign rem_sub = q_bit ? (rem_sh - base_sat) : rem_sh;

  assign in_ready_o = (uword_i.op == OP_LOAD);
  assign in_fire    = in_ready_o && in_valid_i;

  always_comb begin
    unique case (uword_i.op)
      OP_PUT_DIGIT: begin
        put    = 1'b1;
        put_el = {1'b0, rem_q};
      end
      OP_PUT_GAP: begin
        put    = 1'b1;
        put_el = EL_GAP;
      end
      OP_PUT_NEG: begin
        put    = 1'b1;
        put_el = EL_NEG;
      end
      default: begin
        put    = 1'b0;
        put_el = EL_GAP;
      end
    endcase
  end

  assign room      = (count_q < CW'(CAPACITY));
  assign emit_fire = (uword_i.op == OP_EMIT) && (!out_valid_q || out_ready_i);
  assign rd_addr   = count_q - CW'(1) - rp_q;
  assign last      = ((rp_q + CW'(1)) == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= BASE_RESET;
      pad_digits_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUMBER_BASE: base_q       <= cfg_wdata_i[BASE_W-1:0];
        CFG_PAD_DIGITS:  pad_digits_q <= cfg_wdata_i;
        default:         base_q       <= base_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q    <= '0;
      rem_q    <= '0;
      bitcnt_q <= '0;
      neg_q    <= 1'b0;
      digits_q <= '0;
      count_q  <= '0;
      rp_q     <= '0;
    end else begin
      if (in_fire) begin
        mag_q    <= code_abs;
        neg_q    <= code[CODE_WIDTH-1];
        rem_q    <= '0;
        bitcnt_q <= '0;
        digits_q <= '0;
        count_q  <= '0;
        rp_q     <= '0;
      end
      if (uword_i.op == OP_DIV_BIT) begin
        mag_q    <= {mag_q[CODE_WIDTH-2:0], q_bit};
        rem_q    <= rem_sub[3:0];
        bitcnt_q <= bitcnt_q + BCW'(1);
      end
      if (uword_i.op == OP_PUT_DIGIT) begin
        rem_q    <= '0;
        bitcnt_q <= '0;
      end
      if (uword_i.op == OP_PUT_DIGIT || uword_i.op == OP_PUT_GAP) begin
        digits_q <= digits_q + MIND_W'(1);
      end
      // drop elements once the store is full
      if (put && room) begin
        count_q <= count_q + CW'(1);
      end
      if (emit_fire) begin
        rp_q <= rp_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (put && room) begin
      mem[count_q[AW-1:0]] <= put_el;
    end
    if (uword_i.op == OP_READ) begin
      rd_q <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      last_q <= last;
      if (rd_q == EL_NEG) begin
        kind_q  <= KIND_NEG;
        digit_q <= '0;
      end else if (rd_q == EL_GAP) begin
        kind_q  <= KIND_GAP;
        digit_q <= '0;
      end else begin
        kind_q  <= KIND_DIGIT;
        digit_q <= rd_q[3:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {2'b00, digit_q, kind_q};
  assign out_last_o  = last_q;

  assign status_o.in_valid  = in_valid_i;
  assign status_o.more_bits = (bitcnt_q != BCW'(CODE_WIDTH - 1));
  assign status_o.mag_nz    = |mag_q;
  assign status_o.pad_done  = (digits_q >= pad_digits_q);
  assign status_o.neg       = neg_q;
  assign status_o.last      = last;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

[sv/signed_radix_digit_sequencer.sv]
// ----------------------------------------------------------------------------
// signed_radix_digit_sequencer
// Splits a signed code into radix digits and streams them out as elements:
// negative marker, padding gaps, then digits from most to least significant.
//
//   channel   dir  payload
//   s_axis    in   tdata: code_value
//   m_axis    out  tdata: element_kind, digit_value; tlast: last_element
//   cfg       in   index 0 number_base, index 1 pad digit count
//
// Digits come from a restoring divider that yields one quotient bit per cycle.
// Input is taken only at the program's first step; a stalled m_axis holds
// the emit step. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_radix_digit_sequencer #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned CODE_WIDTH = 32,
  localparam int unsigned IN_W      = ((CODE_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [IN_W-1:0]                  s_axis_tdata,  // [CODE_WIDTH-1:0] code_value
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [srds_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [1:0] kind, [5:2] digit
  output logic                             m_axis_tlast,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [srds_pkg::MIND_W-1:0]      cfg_wdata_i
);
  import srds_pkg::*;

  logic [UPC_W-1:0] upc;
  srds_uword_t      uword;
  srds_status_t     status;

  srds_ucode_rom u_rom (
    .upc_i   (upc),
    .uword_o (uword)
  );

  srds_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .uword_i  (uword),
    .status_i (status),
    .upc_o    (upc)
  );

  srds_datapath #(
    .CAPACITY   (CAPACITY),
    .CODE_WIDTH (CODE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uword_i     (uword),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

[sv/srds_checker.sv]
// ----------------------------------------------------------------------------
// srds_checker
// Port-level checks of the signed radix digit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_radix_digit_sequencer_macros.svh"

module srds_checker (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid,
  input  wire                             s_axis_tready,
  input  wire                             m_axis_tvalid,
  input  wire                             m_axis_tready,
  input  wire [srds_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire                             m_axis_tlast
);
  import srds_pkg::*;

  // a stalled result holds
  `SRDS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // one code at a time: input closes right after a transaction
  `SRDS_ASSERT_NEXT(a_in_single, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input stayed open after a transaction")

  // digit elements carry a nonzero digit, other kinds carry zero
  `SRDS_ASSERT_NOW(a_digit_kind, m_axis_tvalid, (m_axis_tdata[1:0] == KIND_DIGIT) == (m_axis_tdata[5:2] != 4'd0), "digit field does not match kind")

  `SRDS_ASSERT_NOW(a_pad_bits, m_axis_tvalid, m_axis_tdata[7:6] == 2'b00, "tdata padding bits set")

endmodule

bind signed_radix_digit_sequencer srds_checker u_srds_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// Signed radix digit sequencer testbench
// Streams signed codes into the sequencer under a range of radix and padding
// settings, predicts the element sequence of every accepted code and checks
// each output transaction against it in order, with random stalls on both
// sides, a long output hold-off and idle-only register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import srds_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned CODE_W      = 32;
  localparam int unsigned RANDOM_CODES = 440;
  localparam int unsigned HOLD_CYCLES = 700;
  // Worst code: 32 base-2 digits padded out to 127, 64 emitted elements, each
  // emit stalled by the receiver; taken over every item with margin.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] digit;
    logic       last;
  } element_t;

  class digit_scoreboard;
    logic [BASE_W-1:0] radix_reg;
    logic [MIND_W-1:0] pad_digits_reg;
    element_t          pending_elements[$];
    int unsigned       errors;

    function new();
      radix_reg      = BASE_RESET;
      pad_digits_reg = '0;
      errors         = 0;
    endfunction

    function void set_reg(logic idx, logic [MIND_W-1:0] value);
      if (idx == CFG_NUMBER_BASE) begin
        radix_reg = value[BASE_W-1:0];
      end else begin
        pad_digits_reg = value;
      end
    endfunction

    function int unsigned pending();
      return pending_elements.size();
    endfunction

    // Gather digits least significant first, pad, add the sign marker,
    // then queue the gathered elements in reverse order.
    function void note_code(logic [CODE_W-1:0] code);
      logic [4:0]        gathered[CAPACITY];
      logic [CODE_W-1:0] mag;
      logic              neg;
      int unsigned       radix;
      int unsigned       n_gathered;
      int unsigned       n_digits;
      int unsigned       d;
      element_t          el;
      neg = code[CODE_W-1];
      mag = neg ? (~code + CODE_W'(1)) : code;
      if (radix_reg < BASE_MIN) begin
        radix = 32'(BASE_MIN);
      end else if (radix_reg > BASE_MAX) begin
        radix = 32'(BASE_MAX);
      end else begin
        radix = 32'(radix_reg);
      end
      n_gathered = 0;
      n_digits = 0;
      do begin
        d = mag % radix;
        mag = mag / radix;
        if (n_gathered < CAPACITY) begin
          gathered[n_gathered] = (d == 0) ? EL_GAP : 5'(d);
          n_gathered++;
        end
        n_digits++;
      end while (mag != 0);
      while (n_digits < 32'(pad_digits_reg)) begin
        if (n_gathered < CAPACITY) begin
          gathered[n_gathered] = EL_GAP;
          n_gathered++;
        end
        n_digits++;
      end
      if (neg && n_gathered < CAPACITY) begin
        gathered[n_gathered] = EL_NEG;
        n_gathered++;
      end
      for (int i = int'(n_gathered) - 1; i >= 0; i--) begin
        if (gathered[i] == EL_NEG) begin
          el.kind  = KIND_NEG;
          el.digit = '0;
        end else if (gathered[i] == EL_GAP) begin
          el.kind  = KIND_GAP;
          el.digit = '0;
        end else begin
          el.kind  = KIND_DIGIT;
          el.digit = gathered[i][3:0];
        end
        el.last = (i == 0);
        pending_elements.push_back(el);
      end
    endfunction

    function void check_element(logic [1:0] kind, logic [3:0] digit, logic last);
      element_t want;
      if (pending_elements.size() == 0) begin
        $error("unexpected element: kind %0d digit %0d last %0d", kind, digit, last);
        errors++;
        return;
      end
      want = pending_elements.pop_front();
      if (kind !== want.kind) begin
        $error("element_kind: expected %0d, got %0d", want.kind, kind);
        errors++;
      end
      if (digit !== want.digit) begin
        $error("digit_value: expected %0d, got %0d", want.digit, digit);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_element: expected %0d, got %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [CODE_W-1:0]      s_axis_tdata;   // [31:0] code_value
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [1:0] element_kind, [5:2] digit_value
  logic                   m_axis_tlast;
  logic                   cfg_we_i;
  logic                   cfg_idx_i;
  logic [MIND_W-1:0]      cfg_wdata_i;

  digit_scoreboard sb = new();

  int unsigned src_idle_pct;
  int unsigned dst_idle_pct;
  int unsigned hold_req_seq;
  int unsigned hold_req_len;

  signed_radix_digit_sequencer #(
    .CAPACITY  (CAPACITY),
    .CODE_WIDTH(CODE_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Output side: random stalls, plus a long hold-off on request.
  initial begin
    int unsigned hold_left;
    int unsigned seen_seq;
    hold_left = 0;
    seen_seq = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req_seq != seen_seq) begin
        seen_seq = hold_req_seq;
        hold_left = hold_req_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_element(m_axis_tdata[1:0], m_axis_tdata[5:2], m_axis_tlast);
    end
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic send_code(input logic [CODE_W-1:0] code);
    int unsigned gap;
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_code(code);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [MIND_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    sb.set_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input logic [MIND_W-1:0] radix,
                               input logic [MIND_W-1:0] pad_digits);
    wait_drained();
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_NUMBER_BASE, radix);
      write_reg(CFG_PAD_DIGITS, pad_digits);
    end else begin
      write_reg(CFG_PAD_DIGITS, pad_digits);
      write_reg(CFG_NUMBER_BASE, radix);
    end
  endtask

  // The most negative code is skipped; it is replaced by the one above it.
  function automatic logic [CODE_W-1:0] pick_code();
    logic [CODE_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 40);
      1: v = 32'd0 - $urandom_range(1, 40);
      2: begin
        v = $urandom() >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = ~v + 32'd1;
      end
      default: v = $urandom();
    endcase
    if (v == 32'h8000_0000) v = 32'h8000_0001;
    return v;
  endfunction

  function automatic logic [MIND_W-1:0] pick_radix();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return MIND_W'($urandom_range(0, 1));
    if (r < 14) return MIND_W'($urandom_range(17, 31));
    return MIND_W'($urandom_range(2, 16));
  endfunction

  function automatic logic [MIND_W-1:0] pick_pad_digits();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return MIND_W'($urandom_range(0, 4));
    if (r < 92) return MIND_W'($urandom_range(5, 20));
    return MIND_W'($urandom_range(21, 127));
  endfunction

  initial begin
    int unsigned sent;
    int unsigned seg_len;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_NUMBER_BASE;
    cfg_wdata_i   = '0;
    src_idle_pct  = 13;
    dst_idle_pct  = 49;
    hold_req_seq  = 0;
    hold_req_len  = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset setting first, then the saturation and overflow corners.
    send_code(32'd0);
    send_code(32'd1);
    send_code(32'hFFFF_FFFF);
    send_code(32'h7FFF_FFFF);
    send_code(32'h8000_0001);
    send_code(32'd1_000_000_007);
    send_code(-32'sd90);
    // Full store: the sign marker of a negative code gets dropped.
    apply_setting(7'd2, 7'd64);
    send_code(32'd0);
    send_code(32'hFFFF_FFFF);
    send_code(32'h7FFF_FFFF);
    send_code(-32'sd5);
    // Padding far past capacity.
    apply_setting(7'd16, 7'd127);
    send_code(32'hFFFF_FFFF);
    send_code(32'h8000_0001);
    send_code(32'd0);
    // Radix below two saturates to two.
    apply_setting(7'd0, 7'd0);
    send_code(32'd5);
    send_code(-32'sd6);
    apply_setting(7'd1, 7'd3);
    send_code(32'd7);
    // Radix above sixteen saturates to sixteen.
    apply_setting(7'd17, 7'd1);
    send_code(32'd255);
    send_code(-32'sd256);
    apply_setting(7'd31, 7'd0);
    send_code(32'h7FFF_FFFF);
    apply_setting(7'd3, 7'd20);
    send_code(-32'sd12345);

    // Hold the output off long enough that the input backs up.
    apply_setting(7'd2, 7'd40);
    hold_req_len = HOLD_CYCLES;
    hold_req_seq++;
    repeat (8) send_code(32'h8000_0001 | $urandom());
    wait_drained();

    sent = 0;
    while (sent < RANDOM_CODES) begin
      if (sent >= (2 * RANDOM_CODES) / 3) begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end else if (sent >= RANDOM_CODES / 3) begin
        src_idle_pct = 49;
        dst_idle_pct = 13;
      end
      apply_setting(pick_radix(), pick_pad_digits());
      seg_len = $urandom_range(15, 40);
      repeat (seg_len) begin
        if (sent < RANDOM_CODES) begin
          send_code(pick_code());
          sent++;
        end
      end
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
